// ===== design/prs_pkg.sv =====
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types and codes for the prime range sum unit: item structs,
// status codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int BoundW  = 16;
  localparam int SumW    = 32;
  localparam int StatusW = 2;

  localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatusW-1:0] STATUS_A_ZERO    = 2'd1;
  localparam logic [StatusW-1:0] STATUS_A_NOT_LESS = 2'd2;

  typedef struct packed {
    logic [BoundW-1:0] lower_bound;
    logic [BoundW-1:0] upper_bound;
  } prs_in_t;

  typedef struct packed {
    logic [SumW-1:0]    prime_sum;
    logic [StatusW-1:0] status;
  } prs_out_t;

  // controller -> datapath
  typedef struct packed {
    logic               load_in;
    logic               init_run;
    logic               start_test;
    logic               start_mod;
    logic               next_div;
    logic               add_prime;
    logic               next_cand;
    logic               load_out;
    logic [StatusW-1:0] status;
  } prs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic a_zero;
    logic a_ge_b;
    logic cand_lt_b;
    logic sq_gt_n;
    logic mod_busy;
    logic rem_zero;
    logic out_free;
  } prs_sts_t;

endpackage

// ===== design/prs_mod.sv =====
// ----------------------------------------------------------------------------
// prs_mod
// Iterative restoring modulo unit: one quotient bit per cycle, result
// remainder valid when busy falls.
// ----------------------------------------------------------------------------
module prs_mod #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                   busy_o,
  output logic [VALUE_WIDTH-1:0] rem_o
);

  localparam int CntW = $clog2(VALUE_WIDTH + 1);

  logic                   busy_q, busy_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] sh_q, sh_d;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;

  assign trial = {rem_q, sh_q[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(VALUE_WIDTH);
      rem_d  = '0;
      sh_d   = dividend_i;
    end else if (busy_q) begin
      // subtract when the shifted remainder reaches the divisor
      rem_d  = diff[VALUE_WIDTH] ? trial[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
      sh_d   = {sh_q[VALUE_WIDTH-2:0], 1'b0};
      cnt_d  = cnt_q - CntW'(1);
      busy_d = (cnt_q != CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

// ===== design/prs_ctrl.sv =====
// ----------------------------------------------------------------------------
// prs_ctrl
// Sequencer for one query: bound checks, candidate walk, trial division
// loop and result hand-off.
// ----------------------------------------------------------------------------
module prs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  prs_pkg::prs_sts_t sts_i,
  output prs_pkg::prs_cmd_t cmd_o
);

  import prs_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_CAND  = 3'd2;
  localparam logic [2:0] ST_TEST  = 3'd3;
  localparam logic [2:0] ST_MODW  = 3'd4;
  localparam logic [2:0] ST_WRITE = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [StatusW-1:0] stat_q, stat_d;

  always_comb begin
    state_d = state_q;
    stat_d  = stat_q;
    cmd_o   = '0;
    cmd_o.status = stat_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        priority if (sts_i.a_zero) begin
          stat_d  = STATUS_A_ZERO;
          state_d = ST_WRITE;
        end else if (sts_i.a_ge_b) begin
          stat_d  = STATUS_A_NOT_LESS;
          state_d = ST_WRITE;
        end else begin
          stat_d         = STATUS_OK;
          cmd_o.init_run = 1'b1;
          state_d        = ST_CAND;
        end
      end
      ST_CAND: begin
        if (sts_i.cand_lt_b) begin
          cmd_o.start_test = 1'b1;
          state_d          = ST_TEST;
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_TEST: begin
        // divisor squared past the candidate: no factor found
        if (sts_i.sq_gt_n) begin
          cmd_o.add_prime = 1'b1;
          state_d         = ST_CAND;
        end else begin
          cmd_o.start_mod = 1'b1;
          state_d         = ST_MODW;
        end
      end
      ST_MODW: begin
        if (!sts_i.mod_busy) begin
          if (sts_i.rem_zero) begin
            cmd_o.next_cand = 1'b1;
            state_d         = ST_CAND;
          end else begin
            cmd_o.next_div = 1'b1;
            state_d        = ST_TEST;
          end
        end
      end
      ST_WRITE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stat_q  <= STATUS_OK;
    end else begin
      state_q <= state_d;
      stat_q  <= stat_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // the modulo unit is only started from the divisor test state, never while running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_mod |-> !sts_i.mod_busy)
    else $error("modulo unit started while busy");

endmodule

// ===== design/prs_datapath.sv =====
// ----------------------------------------------------------------------------
// prs_datapath
// Bounds, candidate, divisor and its square, saturating sum, single modulo
// unit and the output register.
// ----------------------------------------------------------------------------
module prs_datapath #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  prs_pkg::prs_in_t  in_data_i,
  input  prs_pkg::prs_cmd_t cmd_i,
  output prs_pkg::prs_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output prs_pkg::prs_out_t out_data_o
);

  import prs_pkg::*;

  localparam int ExtW = (VALUE_WIDTH > BoundW) ? VALUE_WIDTH : BoundW;

  logic [ExtW-1:0]        lo_ext, hi_ext;
  logic [VALUE_WIDTH-1:0] a_q, b_q;
  logic [VALUE_WIDTH-1:0] cand_q;
  logic [VALUE_WIDTH-1:0] div_q;
  logic [VALUE_WIDTH:0]   sq_q;
  logic [SumW-1:0]        sum_q;
  logic [SumW:0]          sum_wide;
  logic                   out_valid_q;
  prs_out_t               out_q;
  logic                   mod_busy;
  logic [VALUE_WIDTH-1:0] rem;

  assign lo_ext   = ExtW'(in_data_i.lower_bound);
  assign hi_ext   = ExtW'(in_data_i.upper_bound);
  assign sum_wide = {1'b0, sum_q} + (SumW + 1)'(cand_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      a_q <= lo_ext[VALUE_WIDTH-1:0];
      b_q <= hi_ext[VALUE_WIDTH-1:0];
    end
    // walk starts just above the lower bound
    priority if (cmd_i.init_run) begin
      cand_q <= a_q + VALUE_WIDTH'(1);
    end else if (cmd_i.add_prime || cmd_i.next_cand) begin
      cand_q <= cand_q + VALUE_WIDTH'(1);
    end
    if (cmd_i.init_run) begin
      sum_q <= '0;
    end else if (cmd_i.add_prime) begin
      sum_q <= sum_wide[SumW] ? {SumW{1'b1}} : sum_wide[SumW-1:0];
    end
    priority if (cmd_i.start_test) begin
      div_q <= VALUE_WIDTH'(2);
      sq_q  <= (VALUE_WIDTH + 1)'(4);
    end else if (cmd_i.next_div) begin
      // (d+1)^2 = d^2 + 2d + 1
      div_q <= div_q + VALUE_WIDTH'(1);
      sq_q  <= sq_q + {div_q, 1'b1};
    end
    if (cmd_i.load_out) begin
      out_q.status    <= cmd_i.status;
      out_q.prime_sum <= (cmd_i.status == STATUS_OK) ? sum_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  prs_mod #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_mod),
    .dividend_i (cand_q),
    .divisor_i  (div_q),
    .busy_o     (mod_busy),
    .rem_o      (rem)
  );

  assign sts_o.a_zero    = (a_q == '0);
  assign sts_o.a_ge_b    = (a_q >= b_q);
  assign sts_o.cand_lt_b = (cand_q < b_q);
  assign sts_o.sq_gt_n   = (sq_q > {1'b0, cand_q});
  assign sts_o.mod_busy  = mod_busy;
  assign sts_o.rem_zero  = (rem == '0);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // finished remainder is always below the divisor it was taken against
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mod_busy && $past(mod_busy) |-> rem < div_q)
    else $error("remainder not below divisor");

  // saturating sum never goes down while primes are added
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add_prime |=> sum_q >= $past(sum_q))
    else $error("running sum decreased");

  // every tested candidate lies above the lower bound and is at least two
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start_test |-> (cand_q > a_q) && (cand_q >= VALUE_WIDTH'(2)))
    else $error("candidate outside range");

endmodule

// ===== design/prime_range_sum_unit.sv =====
// For a bound error the result is valid once the query has passed the bound
// check and write states. A valid query walks every candidate from A+1 to B-1;
// each trial divisor takes a square check plus a run of the bit-serial modulo unit.
// Throughput: one item at a time; the next item is taken once the result is
// in the output register, which holds it until taken.
// Reset: asynchronous, clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
// prime_range_sum_unit
// Sum of the primes strictly between two bounds, by trial division, with a
// status code for bad bounds.
// ----------------------------------------------------------------------------
module prime_range_sum_unit #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  prs_pkg::prs_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output prs_pkg::prs_out_t out_data_o
);

  import prs_pkg::*;

  prs_cmd_t cmd;
  prs_sts_t sts;

  prs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prs_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // an accepted item keeps the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not held off after accept");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for prime_range_sum_unit. Queries go in over a
// valid/stall channel and every result is checked against sums worked out in
// the bench by trial division. It runs a directed set of bound corners, a burst
// against a held-off output, then random queries with mostly short ranges.
// ----------------------------------------------------------------------------
module tb_top;
  import prs_pkg::*;

  localparam int          BOUND_BITS  = 16;
  localparam int unsigned CYCLE_LIMIT = 16_000_000;
  localparam int          RAND_ITEMS  = 72;
  localparam int          DRAIN_WAIT  = 20;
  localparam int          HOLD_CYCLES = 40_000;

  // ordered store of expected sums, one per accepted query
  class prime_sum_ledger;
    prs_out_t owed[$];
    int       failures;
    int       reported;

    function bit prime_by_trial(longint unsigned n);
      longint unsigned d;
      if (n < 2) return 1'b0;
      for (d = 2; d * d <= n; d++) begin
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function prs_out_t range_prime_sum(prs_in_t q);
      longint unsigned mask, lo, hi, n, acc;
      prs_out_t        r;
      mask        = (64'd1 << BOUND_BITS) - 1;
      lo          = q.lower_bound & mask;
      hi          = q.upper_bound & mask;
      r.prime_sum = '0;
      if (lo == 0) begin
        r.status = STATUS_A_ZERO;
      end else if (lo >= hi) begin
        r.status = STATUS_A_NOT_LESS;
      end else begin
        r.status = STATUS_OK;
        acc      = 0;
        for (n = lo + 1; n < hi; n++) begin
          if (prime_by_trial(n)) begin
            acc += n;
            if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
          end
        end
        r.prime_sum = acc[31:0];
      end
      return r;
    endfunction

    function void complain(string what);
      failures++;
      if (reported < 10) begin
        reported++;
        $display("[%0t] error: %s", $time, what);
      end
    endfunction

    function void note_query(prs_in_t q);
      owed.push_back(range_prime_sum(q));
    endfunction

    function void check_result(prs_out_t got);
      prs_out_t want;
      if (owed.size() == 0) begin
        complain($sformatf("unexpected result sum=%0d status=%0d", got.prime_sum, got.status));
        return;
      end
      want = owed.pop_front();
      if (got.prime_sum !== want.prime_sum)
        complain($sformatf("prime_sum expected %0d got %0d", want.prime_sum, got.prime_sum));
      if (got.status !== want.status)
        complain($sformatf("status expected %0d got %0d", want.status, got.status));
    endfunction

    function void close_out();
      if (owed.size() != 0)
        complain($sformatf("%0d results never arrived", owed.size()));
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  prs_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  prs_out_t out_data_o;

  prime_sum_ledger ledger = new;
  int              hold_asks = 0;

  prime_range_sum_unit #(
    .VALUE_WIDTH(BOUND_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short ranges, since a prime near the top is tried against every divisor up to its root
  function automatic prs_in_t random_query();
    prs_in_t     q;
    int unsigned pick, span, lo;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      q.lower_bound = '0;
      q.upper_bound = 16'($urandom);
    end else if (pick < 16) begin
      q.lower_bound = 16'($urandom_range(1, 65535));
      q.upper_bound = 16'($urandom_range(0, q.lower_bound));
    end else if (pick < 30) begin
      lo            = $urandom_range(1, 65535);
      span          = $urandom_range(1, 12);
      q.lower_bound = 16'(lo);
      q.upper_bound = (lo + span > 65535) ? 16'hFFFF : 16'(lo + span);
    end else begin
      lo            = $urandom_range(1, 1000);
      q.lower_bound = 16'(lo);
      q.upper_bound = 16'(lo + $urandom_range(1, 48));
    end
    return q;
  endfunction

  task automatic send_query(input prs_in_t q, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= q;
    do @(posedge clk_i); while (in_stall_o);
    ledger.note_query(q);
  endtask

  task automatic send_pair(input int unsigned a, input int unsigned b);
    prs_in_t q;
    q.lower_bound = 16'(a);
    q.upper_bound = 16'(b);
    send_query(q, $urandom_range(0, 17));
  endtask

  // stop offering so the last item is not taken twice
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (ledger.owed.size() != 0) @(posedge clk_i);
  endtask

  // result side: random stall per item, eager stretches, one long hold-off
  initial begin
    int wait_left, hold_left, hold_seen, taken;
    bit eager;
    wait_left = 0;
    hold_left = 0;
    hold_seen = 0;
    taken     = 0;
    eager     = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        ledger.check_result(out_data_o);
        taken++;
        if (taken % 16 == 0) eager = ($urandom_range(0, 3) == 0);
        wait_left = eager ? 0 : $urandom_range(0, 17);
      end
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("** prime_range_sum_unit: FAILED **");
    $finish;
  end

  initial begin
    bit eager;
    eager = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bound errors, empty ranges and corners of the field range
    send_pair(0, 0);
    send_pair(0, 65535);
    send_pair(65535, 0);
    send_pair(65535, 65535);
    send_pair(7, 7);
    send_pair(9, 3);
    send_pair(1, 2);
    send_pair(1, 3);
    send_pair(2, 3);
    send_pair(3, 5);
    send_pair(4, 6);
    send_pair(5, 7);
    send_pair(13, 17);
    send_pair(1, 10);
    send_pair(2, 100);
    send_pair(1, 200);
    send_pair(100, 128);
    send_pair(32768, 32800);
    send_pair(65520, 65535);
    send_pair(65534, 65535);

    // output held off while items keep coming, so the input backs up
    wait_drained();
    hold_asks++;
    repeat (8) send_query(random_query(), 0);
    wait_drained();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 16 == 0) eager = ($urandom_range(0, 3) == 0);
      send_query(random_query(), eager ? 0 : $urandom_range(0, 17));
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    ledger.close_out();
    if (ledger.failures == 0) begin
      $display("** prime_range_sum_unit: PASSED **");
    end else begin
      $display("** prime_range_sum_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/prs_pkg.sv
design/prs_mod.sv
design/prs_ctrl.sv
design/prs_datapath.sv
design/prime_range_sum_unit.sv
bench/tb_top.sv
